@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the controller top file
// Clocked concurrent checks with an active-high reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication with the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/onlc_pkg.sv @@
// ---------------------------------------------------------------------------
// Night lamp controller package
// Register indexes, reset values, widths and state codes.
// ---------------------------------------------------------------------------
`default_nettype none

package onlc_pkg;

   // Sample window length default (light must read dark this many ticks)
   localparam int WINDOW_DEFAULT = 128;

   // Field and register widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int HOLD_W     = 16;
   localparam int CNT_W      = 10;

   // Register reset values
   localparam logic              AUTO_ENABLE_RST       = 1'b1;
   localparam logic [HOLD_W-1:0] HOLD_DURATION_RST     = 16'd30;
   localparam logic [HOLD_W-1:0] SHORT_HOLD_RST        = 16'd3;
   localparam logic [HOLD_W-1:0] RELOAD_AFTER_OFF_RST  = 16'd3200;
   localparam logic [CNT_W-1:0]  PRESENCE_DEBOUNCE_RST = 10'd10;
   localparam logic [CNT_W-1:0]  ABSENCE_DEBOUNCE_RST  = 10'd500;
   localparam logic [CNT_W-1:0]  STARTUP_TICKS_RST     = 10'd500;
   localparam logic [CNT_W-1:0]  QUIET_TICKS_RST       = 10'd100;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AUTO_ENABLE       = 3'd0,
      REG_HOLD_DURATION     = 3'd1,
      REG_SHORT_HOLD        = 3'd2,
      REG_RELOAD_AFTER_OFF  = 3'd3,
      REG_PRESENCE_DEBOUNCE = 3'd4,
      REG_ABSENCE_DEBOUNCE  = 3'd5,
      REG_STARTUP_TICKS     = 3'd6,
      REG_QUIET_TICKS       = 3'd7
   } csr_index_type;

   // Reported presence, with an unknown state after reset
   typedef enum logic [1:0] {
      PRES_ABSENT  = 2'd0,
      PRES_PRESENT = 2'd1,
      PRES_UNKNOWN = 2'd2
   } presence_type;

   // Darkness seen while the lamp was off, unknown after reset
   typedef enum logic [1:0] {
      DARK_NO      = 2'd0,
      DARK_YES     = 2'd1,
      DARK_UNKNOWN = 2'd2
   } dark_off_type;

endpackage

`default_nettype wire

@@ rtl/occupancy_night_lamp_controller_top.sv @@
// ---------------------------------------------------------------------------
// Occupancy night lamp controller
// Tick-driven darkness, presence and lamp hold-timer control.
// ---------------------------------------------------------------------------
// One request is one sensor tick. The request updates the controller state
// at the clock edge it is taken, and its result lands in an output register,
// so a new request is taken in every cycle (one tick per cycle) as long as
// the result side keeps up; a stalled result holds only while rsp_tready is
// low. After reset the first startup_ticks ticks and, from a quiet request
// on, quiet_ticks ticks are reported as skipped. Darkness is qualified after
// WINDOW dark ticks in a row. Registers are written through
// csr_we/csr_index/csr_wdata while no tick is in flight: the user must keep
// to this, the block itself does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module occupancy_night_lamp_controller_top #(
   parameter int WINDOW = onlc_pkg::WINDOW_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [0] light_pin, [1] motion_pin, [2] lamp_is_on, [3] key_press,
   //          [4] quiet_request, [5] off_tick, [7:6] zero
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [onlc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result: [0] lamp_on_request, [1] lamp_off_request, [2] presence_report,
   //         [3] presence_state, [4] is_dark, [5] sensing_skipped, [7:6] zero
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [onlc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write port
   input  wire logic                             csr_we,
   input  wire logic [onlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [onlc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import onlc_pkg::*;

   localparam int TsbW = $clog2(WINDOW + 1);
   localparam logic [TsbW-1:0]  WinVal = TsbW'(WINDOW);
   localparam logic [CNT_W-1:0] CntMax = {CNT_W{1'b1}};

   // configuration registers
   logic              auto_enable_ff;
   logic [HOLD_W-1:0] hold_duration_ff, short_hold_ff, reload_after_off_ff;
   logic [CNT_W-1:0]  presence_debounce_ff, absence_debounce_ff;
   logic [CNT_W-1:0]  startup_ticks_ff, quiet_ticks_ff;

   // controller state and next values
   logic [CNT_W-1:0]  startup_count_ff, startup_count_in;
   logic              quiet_active_ff, quiet_active_in;
   logic [CNT_W-1:0]  quiet_count_ff, quiet_count_in;
   logic [TsbW-1:0]   ticks_since_bright_ff, ticks_since_bright_in;
   presence_type      reported_presence_ff, reported_presence_in;
   logic [CNT_W-1:0]  presence_count_ff, presence_count_in;
   logic [CNT_W-1:0]  absence_count_ff, absence_count_in;
   dark_off_type      dark_when_lamp_off_ff, dark_when_lamp_off_in;
   logic              previous_dark_ff, previous_dark_in;
   logic              key_pending_ff, key_pending_in;
   logic [HOLD_W-1:0] off_countdown_ff, off_countdown_in;

   // output register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // request fields
   logic light, motion, lamp, key_press, quiet_request, off_tick;
   logic req_take;
   logic on_req, off_req, report, skip, dark;

   assign light         = req_tdata[0];
   assign motion        = req_tdata[1];
   assign lamp          = req_tdata[2];
   assign key_press     = req_tdata[3];
   assign quiet_request = req_tdata[4];
   assign off_tick      = req_tdata[5];

   // take a request when the output register is empty or drains this cycle
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_enable_ff       <= AUTO_ENABLE_RST;
         hold_duration_ff     <= HOLD_DURATION_RST;
         short_hold_ff        <= SHORT_HOLD_RST;
         reload_after_off_ff  <= RELOAD_AFTER_OFF_RST;
         presence_debounce_ff <= PRESENCE_DEBOUNCE_RST;
         absence_debounce_ff  <= ABSENCE_DEBOUNCE_RST;
         startup_ticks_ff     <= STARTUP_TICKS_RST;
         quiet_ticks_ff       <= QUIET_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_AUTO_ENABLE:       auto_enable_ff       <= csr_wdata[0];
            REG_HOLD_DURATION:     hold_duration_ff     <= csr_wdata;
            REG_SHORT_HOLD:        short_hold_ff        <= csr_wdata;
            REG_RELOAD_AFTER_OFF:  reload_after_off_ff  <= csr_wdata;
            REG_PRESENCE_DEBOUNCE: presence_debounce_ff <= csr_wdata[CNT_W-1:0];
            REG_ABSENCE_DEBOUNCE:  absence_debounce_ff  <= csr_wdata[CNT_W-1:0];
            REG_STARTUP_TICKS:     startup_ticks_ff     <= csr_wdata[CNT_W-1:0];
            REG_QUIET_TICKS:       quiet_ticks_ff       <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // evaluate one tick
   always_comb begin
      startup_count_in      = startup_count_ff;
      quiet_active_in       = quiet_active_ff;
      quiet_count_in        = quiet_count_ff;
      ticks_since_bright_in = ticks_since_bright_ff;
      reported_presence_in  = reported_presence_ff;
      presence_count_in     = presence_count_ff;
      absence_count_in      = absence_count_ff;
      dark_when_lamp_off_in = dark_when_lamp_off_ff;
      previous_dark_in      = previous_dark_ff;
      key_pending_in        = key_pending_ff | key_press;
      off_countdown_in      = off_countdown_ff;
      on_req  = 1'b0;
      off_req = 1'b0;
      report  = 1'b0;
      skip    = 1'b0;

      // latch a quiet request ahead of the tick
      if (quiet_request) begin
         quiet_active_in = 1'b1;
         quiet_count_in  = '0;
      end

      // advance the off countdown, also on skipped ticks
      if (off_tick) begin
         if (off_countdown_ff == '0) begin
            if (auto_enable_ff) begin
               off_req          = 1'b1;
               off_countdown_in = reload_after_off_ff;
            end
         end else begin
            off_countdown_in = off_countdown_ff - HOLD_W'(1);
         end
      end

      // start-up and quiet periods
      if (startup_count_ff < startup_ticks_ff) begin
         startup_count_in = startup_count_ff + CNT_W'(1);
         skip             = 1'b1;
      end else begin
         startup_count_in = startup_ticks_ff;
         if (quiet_active_in) begin
            if (quiet_count_in >= quiet_ticks_ff) begin
               quiet_count_in  = '0;
               quiet_active_in = 1'b0;
            end else begin
               quiet_count_in = quiet_count_in + CNT_W'(1);
               skip           = 1'b1;
            end
         end
      end

      if (!skip) begin
         // darkness window as a saturating run length
         if (light) begin
            if (ticks_since_bright_ff < WinVal) begin
               ticks_since_bright_in = ticks_since_bright_ff + TsbW'(1);
            end
         end else begin
            ticks_since_bright_in = '0;
         end
         if (!lamp) begin
            dark_when_lamp_off_in = (ticks_since_bright_in >= WinVal) ? DARK_YES : DARK_NO;
         end

         // presence debounce
         if (motion) begin
            if (reported_presence_ff != PRES_PRESENT) begin
               if (presence_count_ff != CntMax) begin
                  presence_count_in = presence_count_ff + CNT_W'(1);
               end
               if (presence_count_ff > presence_debounce_ff) begin
                  reported_presence_in = PRES_PRESENT;
                  report               = 1'b1;
                  presence_count_in    = '0;
               end
            end
            absence_count_in = '0;
         end else begin
            if (reported_presence_ff != PRES_ABSENT) begin
               if (absence_count_ff != CntMax) begin
                  absence_count_in = absence_count_ff + CNT_W'(1);
               end
               if (absence_count_ff > absence_debounce_ff) begin
                  reported_presence_in = PRES_ABSENT;
                  report               = 1'b1;
                  absence_count_in     = '0;
               end
            end
            presence_count_in = '0;
         end

         // automatic lamp control
         if (auto_enable_ff) begin
            if (ticks_since_bright_in >= WinVal) begin
               if (motion) begin
                  on_req           = !lamp;
                  off_countdown_in = hold_duration_ff;
               end else if (lamp && (reported_presence_in == PRES_PRESENT ||
                                     key_pending_in)) begin
                  off_countdown_in = hold_duration_ff;
                  key_pending_in   = 1'b0;
               end
            end else begin
               // first dark-to-bright change after reset
               if (previous_dark_ff) begin
                  if (lamp && dark_when_lamp_off_in == DARK_YES) begin
                     off_countdown_in = hold_duration_ff;
                  end else if (lamp && dark_when_lamp_off_in == DARK_NO) begin
                     off_countdown_in = short_hold_ff;
                  end
                  previous_dark_in = 1'b0;
               end
               if (key_pending_in && lamp) begin
                  key_pending_in   = 1'b0;
                  off_countdown_in = (dark_when_lamp_off_in == DARK_NO) ?
                                     short_hold_ff : hold_duration_ff;
               end
            end
         end
      end

      dark = (ticks_since_bright_in >= WinVal);
      rsp_tdata_in = {2'b00, skip, dark, (reported_presence_in == PRES_PRESENT),
                      report, off_req, on_req};
   end

   // hold state, advance on a taken request
   always_ff @(posedge clock) begin
      if (reset) begin
         startup_count_ff      <= '0;
         quiet_active_ff       <= 1'b0;
         quiet_count_ff        <= '0;
         ticks_since_bright_ff <= WinVal;
         reported_presence_ff  <= PRES_UNKNOWN;
         presence_count_ff     <= '0;
         absence_count_ff      <= '0;
         dark_when_lamp_off_ff <= DARK_UNKNOWN;
         previous_dark_ff      <= 1'b1;
         key_pending_ff        <= 1'b0;
         off_countdown_ff      <= '0;
      end else if (req_take) begin
         startup_count_ff      <= startup_count_in;
         quiet_active_ff       <= quiet_active_in;
         quiet_count_ff        <= quiet_count_in;
         ticks_since_bright_ff <= ticks_since_bright_in;
         reported_presence_ff  <= reported_presence_in;
         presence_count_ff     <= presence_count_in;
         absence_count_ff      <= absence_count_in;
         dark_when_lamp_off_ff <= dark_when_lamp_off_in;
         previous_dark_ff      <= previous_dark_in;
         key_pending_ff        <= key_pending_in;
         off_countdown_ff      <= off_countdown_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // checks
   `ASSERT_CLK(a_skip_quiet, clock, reset,
      !(rsp_tvalid_ff && rsp_tdata_ff[5] && (rsp_tdata_ff[0] || rsp_tdata_ff[2])),
      "skipped tick raised a lamp-on request or a presence report")
   `ASSERT_CLK(a_window_bound, clock, reset, ticks_since_bright_ff <= WinVal,
      "darkness run length beyond the window")
   `ASSERT_NEXT(a_motion_clears_absence, clock, reset, req_take && !skip && motion,
      absence_count_ff == '0, "sensed motion left the absence count running")
   `ASSERT_NEXT(a_countdown_holds, clock, reset, !req_take, $stable(off_countdown_ff),
      "off countdown moved without a tick")

endmodule

`default_nettype wire

@@ sim/occupancy_night_lamp_controller_top_tb.sv @@
// ---------------------------------------------------------------------------
// Night lamp controller testbench
// Drives sensor ticks into the controller and compares every result with a
// cycle-free prediction of the lamp, presence and darkness logic. The run has
// a short directed opening and then phases of shaped random ticks, each under
// its own register setting, with random idling on both streams and one long
// result-side hold-off that fills the block and stalls its input.
// ---------------------------------------------------------------------------
module occupancy_night_lamp_controller_top_tb;
   import onlc_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;

   // One sensor tick as packed in req_tdata, light_pin in bit 0
   typedef struct packed {
      logic off_tick;
      logic quiet;
      logic key;
      logic lamp;
      logic motion;
      logic light;
   } tick_type;

   // One tick result as packed in rsp_tdata, lamp_on_request in bit 0
   typedef struct packed {
      logic [1:0] pad;
      logic       skipped;
      logic       dark;
      logic       presence;
      logic       report;
      logic       off_req;
      logic       on_req;
   } lamp_result_type;

   // Predicts the result of each tick and checks the results against it
   class lamp_tick_scoreboard;
      // register shadow
      logic        auto_en;
      logic [15:0] hold_ticks, short_ticks, reload_ticks;
      logic [9:0]  presence_deb, absence_deb, startup_len, quiet_len;
      // controller state
      logic [9:0]   startup_cnt, quiet_cnt, pres_cnt, abs_cnt;
      logic         quiet_on, prev_dark, key_latched;
      logic [7:0]   bright_age;
      presence_type presence;
      dark_off_type dark_off;
      logic [15:0]  countdown;

      lamp_result_type pending_lamp_results[$];
      logic            last_on, last_off;
      int              errors;
      int              results_seen;
      string           field_name[6];

      function new();
         auto_en      = AUTO_ENABLE_RST;
         hold_ticks   = HOLD_DURATION_RST;
         short_ticks  = SHORT_HOLD_RST;
         reload_ticks = RELOAD_AFTER_OFF_RST;
         presence_deb = PRESENCE_DEBOUNCE_RST;
         absence_deb  = ABSENCE_DEBOUNCE_RST;
         startup_len  = STARTUP_TICKS_RST;
         quiet_len    = QUIET_TICKS_RST;
         startup_cnt  = '0;
         quiet_cnt    = '0;
         pres_cnt     = '0;
         abs_cnt      = '0;
         quiet_on     = 1'b0;
         prev_dark    = 1'b1;
         key_latched  = 1'b0;
         bright_age   = 8'(WIN);
         presence     = PRES_UNKNOWN;
         dark_off     = DARK_UNKNOWN;
         countdown    = '0;
         last_on      = 1'b0;
         last_off     = 1'b0;
         errors       = 0;
         results_seen = 0;
         field_name   = '{"lamp_on_request", "lamp_off_request", "presence_report",
                          "presence_state", "is_dark", "sensing_skipped"};
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            REG_AUTO_ENABLE:       auto_en      = value[0];
            REG_HOLD_DURATION:     hold_ticks   = value;
            REG_SHORT_HOLD:        short_ticks  = value;
            REG_RELOAD_AFTER_OFF:  reload_ticks = value;
            REG_PRESENCE_DEBOUNCE: presence_deb = value[9:0];
            REG_ABSENCE_DEBOUNCE:  absence_deb  = value[9:0];
            REG_STARTUP_TICKS:     startup_len  = value[9:0];
            REG_QUIET_TICKS:       quiet_len    = value[9:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return pending_lamp_results.size();
      endfunction

      // Advance the state by one accepted tick and queue its result
      function void note_tick(tick_type t);
         lamp_result_type r;
         logic            dark;
         logic [9:0]      old;
         r = '0;
         if (t.key) key_latched = 1'b1;
         if (t.quiet) begin
            quiet_on  = 1'b1;
            quiet_cnt = '0;
         end

         // off countdown runs on skipped ticks too
         if (t.off_tick) begin
            if (countdown == 16'd0) begin
               if (auto_en) begin
                  r.off_req = 1'b1;
                  countdown = reload_ticks;
               end
            end else begin
               countdown = countdown - 16'd1;
            end
         end

         // start-up and quiet periods
         if (startup_cnt < startup_len) begin
            startup_cnt = startup_cnt + 10'd1;
            r.skipped   = 1'b1;
         end else begin
            startup_cnt = startup_len;
            if (quiet_on) begin
               if (quiet_cnt >= quiet_len) begin
                  quiet_cnt = '0;
                  quiet_on  = 1'b0;
               end else begin
                  quiet_cnt = quiet_cnt + 10'd1;
                  r.skipped = 1'b1;
               end
            end
         end

         if (!r.skipped) begin
            // darkness window as a saturating run length
            if (t.light) begin
               if (bright_age < 8'(WIN)) bright_age = bright_age + 8'd1;
            end else begin
               bright_age = '0;
            end
            dark = (bright_age >= 8'(WIN));
            if (!t.lamp) begin
               if (dark) dark_off = DARK_YES;
               else dark_off = DARK_NO;
            end

            // presence debounce, counters saturate at all ones
            if (t.motion) begin
               if (presence != PRES_PRESENT) begin
                  old = pres_cnt;
                  if (old < 10'd1023) pres_cnt = old + 10'd1;
                  if (old > presence_deb) begin
                     presence = PRES_PRESENT;
                     r.report = 1'b1;
                     pres_cnt = '0;
                  end
               end
               abs_cnt = '0;
            end else begin
               if (presence != PRES_ABSENT) begin
                  old = abs_cnt;
                  if (old < 10'd1023) abs_cnt = old + 10'd1;
                  if (old > absence_deb) begin
                     presence = PRES_ABSENT;
                     r.report = 1'b1;
                     abs_cnt  = '0;
                  end
               end
               pres_cnt = '0;
            end

            // automatic lamp control
            if (auto_en) begin
               if (dark) begin
                  if (t.motion) begin
                     if (!t.lamp) r.on_req = 1'b1;
                     countdown = hold_ticks;
                  end else if (t.lamp && (presence == PRES_PRESENT || key_latched)) begin
                     countdown   = hold_ticks;
                     key_latched = 1'b0;
                  end
               end else begin
                  if (prev_dark) begin
                     if (t.lamp && dark_off == DARK_YES) countdown = hold_ticks;
                     else if (t.lamp && dark_off == DARK_NO) countdown = short_ticks;
                     prev_dark = 1'b0;
                  end
                  if (key_latched && t.lamp) begin
                     key_latched = 1'b0;
                     countdown   = (dark_off == DARK_NO) ? short_ticks : hold_ticks;
                  end
               end
            end
         end

         r.dark     = (bright_age >= 8'(WIN));
         r.presence = (presence == PRES_PRESENT);
         pending_lamp_results.push_back(r);
         last_on  = r.on_req;
         last_off = r.off_req;
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      // Compare one accepted result with the oldest prediction
      task check_result(logic [7:0] data);
         logic [7:0] want;
         results_seen++;
         if (pending_lamp_results.size() == 0) begin
            report_mismatch($sformatf("result %0d: no tick waiting, got %h",
                                      results_seen, data));
            return;
         end
         want = pending_lamp_results.pop_front();
         for (int i = 0; i < 6; i++) begin
            if (data[i] !== want[i])
               report_mismatch($sformatf("result %0d: %s got %b want %b", results_seen,
                                         field_name[i], data[i], want[i]));
         end
         if (data[7:6] !== 2'b00)
            report_mismatch($sformatf("result %0d: pad bits %b", results_seen, data[7:6]));
      endtask

      // Report and drop predictions that never got a result
      task flush_leftovers();
         while (pending_lamp_results.size() != 0) begin
            report_mismatch("predicted result never arrived");
            void'(pending_lamp_results.pop_front());
         end
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = REG_AUTO_ENABLE;
   logic [15:0]   csr_wdata = '0;

   lamp_tick_scoreboard sb = new();

   bit   no_idle = 1'b0;
   int   ticks_taken = 0;
   int   hold_left = 0;
   bit   pressure_done = 1'b0;
   bit   light_level = 1'b0, motion_level = 1'b0, lamp_level = 1'b0;
   int   light_left = 0, motion_left = 0;

   occupancy_night_lamp_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side: random stalls, plus one long hold-off once traffic is going
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && ticks_taken >= 700) begin
         hold_left     <= 300;
         pressure_done <= 1'b1;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   function automatic tick_type mk(bit light, bit motion, bit lamp, bit key, bit quiet,
                                   bit off_tick);
      tick_type t;
      t.light    = light;
      t.motion   = motion;
      t.lamp     = lamp;
      t.key      = key;
      t.quiet    = quiet;
      t.off_tick = off_tick;
      return t;
   endfunction

   // Offer one request, with a random gap in front, and note it once taken
   task automatic send_tick(input tick_type t);
      if (!no_idle && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t};
      do @(posedge clock); while (!req_tready);
      ticks_taken++;
      sb.note_tick(t);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      sb.flush_leftovers();
   endtask

   // Write one register; the caller lowers the write enable after a batch
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic configure(input logic auto_en, input logic [15:0] hold,
                            input logic [15:0] short_h, input logic [15:0] reload,
                            input logic [9:0] pres_deb, input logic [9:0] abs_deb,
                            input logic [9:0] startup, input logic [9:0] quiet);
      write_reg(REG_AUTO_ENABLE, {15'd0, auto_en});
      write_reg(REG_HOLD_DURATION, hold);
      write_reg(REG_SHORT_HOLD, short_h);
      write_reg(REG_RELOAD_AFTER_OFF, reload);
      write_reg(REG_PRESENCE_DEBOUNCE, {6'd0, pres_deb});
      write_reg(REG_ABSENCE_DEBOUNCE, {6'd0, abs_deb});
      write_reg(REG_STARTUP_TICKS, {6'd0, startup});
      write_reg(REG_QUIET_TICKS, {6'd0, quiet});
      csr_we <= 1'b0;
   endtask

   // Random ticks with long light and motion runs, the lamp following requests
   task automatic run_phase(input int count, input bit calm);
      tick_type   t;
      logic [5:0] raw;
      no_idle = calm;
      for (int i = 0; i < count; i++) begin
         if (light_left == 0) begin
            light_level = ($urandom_range(99) < 60);
            light_left  = light_level ? $urandom_range(20, 260) : $urandom_range(1, 40);
         end
         if (motion_left == 0) begin
            motion_level = $urandom_range(1);
            motion_left  = ($urandom_range(9) == 0) ? $urandom_range(30, 200)
                                                    : $urandom_range(1, 24);
         end
         light_left--;
         motion_left--;
         t.light  = light_level;
         t.motion = motion_level;
         t.key    = ($urandom_range(99) < 4);
         // a key press stands for a manual lamp switch
         if (t.key) lamp_level = !lamp_level;
         t.lamp     = lamp_level;
         t.quiet    = ($urandom_range(99) < 2);
         t.off_tick = ($urandom_range(99) < 40);
         if ($urandom_range(99) < 8) begin
            raw = $urandom_range(63);
            t   = raw;
         end
         send_tick(t);
         if (sb.last_on) lamp_level = 1'b1;
         if (sb.last_off) lamp_level = 1'b0;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, ticks inside the start-up period
      send_tick(mk(0, 0, 0, 0, 0, 0));
      send_tick(mk(1, 1, 1, 1, 0, 1));
      send_tick(mk(0, 0, 0, 0, 0, 1));
      send_tick(mk(1, 0, 1, 0, 0, 1));
      drain();
      write_reg(REG_STARTUP_TICKS, 16'd0);
      write_reg(REG_QUIET_TICKS, 16'd2);
      csr_we <= 1'b0;

      // Directed: first bright tick with unknown darkness at lamp off, key holds
      send_tick(mk(0, 0, 1, 1, 0, 0));
      send_tick(mk(1, 1, 0, 0, 0, 1));
      send_tick(mk(0, 1, 1, 1, 0, 1));
      // quiet period, then presence debounce and absence
      send_tick(mk(1, 0, 0, 0, 1, 0));
      send_tick(mk(1, 0, 0, 0, 0, 0));
      repeat (12) send_tick(mk(1, 1, 0, 0, 0, 1));
      repeat (3) send_tick(mk(0, 0, 1, 0, 0, 1));
      drain();

      // Random phases under several settings
      configure(1'b1, 16'd40, 16'd4, 16'd9, 10'd3, 10'd12, 10'd0, 10'd5);
      run_phase(250, 1'b1);
      drain();
      configure(1'b1, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_phase(200, 1'b0);
      drain();
      configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1022, 10'd1023, 10'd1023);
      run_phase(120, 1'b0);
      drain();
      configure(1'b0, 16'd20, 16'd3, 16'd50, 10'd2, 10'd8, 10'd0, 10'd3);
      run_phase(200, 1'b0);
      drain();
      for (int p = 0; p < 5; p++) begin
         configure($urandom_range(3) != 0, 16'($urandom_range(60)), 16'($urandom_range(10)),
                   16'($urandom_range(100)), 10'($urandom_range(20)),
                   10'($urandom_range(40)), 10'($urandom_range(15)),
                   10'($urandom_range(30)));
         run_phase(250, 1'b0);
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
